/* rtl/sspst_pkg.sv */
// Package for the slot sensor position and speed tracker.
// Holds widths, codes and the controller-to-datapath command struct.
// No dependencies.
package sspst_pkg;

  // Time and step count widths.
  localparam int TIME_BITS  = 32;
  localparam int COUNT_BITS = 16;

  // Register and field widths.
  localparam int DATA_W     = 16;
  localparam int NOW_W      = 32;
  localparam int DIR_W      = 2;
  localparam int RES_W      = 32;
  localparam int CFG_ADDR_W = 1;

  // Speed is step_distance * 512 / delta.
  localparam int SPEED_SHIFT = 9;
  localparam int DIVD_W      = DATA_W + SPEED_SHIFT;
  localparam int DIV_STEPS   = DIVD_W;
  localparam int CNT_W       = $clog2(DIV_STEPS);

  // Height product: signed count times unsigned distance.
  localparam int PROD_W = COUNT_BITS + DATA_W + 1;
  localparam int EXT_W  = (PROD_W > RES_W + 1) ? PROD_W : RES_W + 1;

  // Stream payload widths, padded to whole bytes.
  localparam int IN_RAW_W  = NOW_W + 1 + DIR_W;
  localparam int IN_W      = ((IN_RAW_W + 7) / 8) * 8;
  localparam int OUT_RAW_W = RES_W + RES_W + DIR_W;
  localparam int OUT_W     = ((OUT_RAW_W + 7) / 8) * 8;

  // Register indexes.
  localparam logic [CFG_ADDR_W-1:0] CFG_MIN_INTERVAL = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_STEP_DIST    = 1'd1;

  localparam logic [DATA_W-1:0] MIN_INTERVAL_RST = 16'd50;
  localparam logic [DATA_W-1:0] STEP_DIST_RST    = 16'd256;

  // Direction codes.
  localparam logic [DIR_W-1:0] DIR_STOP = 2'd0;
  localparam logic [DIR_W-1:0] DIR_UP   = 2'd1;
  localparam logic [DIR_W-1:0] DIR_DOWN = 2'd2;

  typedef struct packed {
    logic load_in;
    logic update;
    logic prep;
    logic div_step;
    logic load_out;
  } cmd_t;

endpackage

/* rtl/sspst_dpath.sv */
// Datapath of the slot sensor tracker: tracking state, height multiplier,
// bit-serial divider for speed and the output register.
// Depends on sspst_pkg.
module sspst_dpath (
  input  logic                            clk,
  input  logic                            rst_n,
  input  sspst_pkg::cmd_t                 cmd,
  input  logic                            cfg_we,
  input  logic [sspst_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sspst_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic [sspst_pkg::IN_W-1:0]       in_tdata,
  output logic [sspst_pkg::OUT_W-1:0]      out_tdata
);

  localparam int TB = sspst_pkg::TIME_BITS;
  localparam int CB = sspst_pkg::COUNT_BITS;

  logic [sspst_pkg::DATA_W-1:0] min_int_r, step_r;

  // Latched input item.
  logic [TB-1:0]                now_r;
  logic                         lvl_r;
  logic [sspst_pkg::DIR_W-1:0]  dir_r;

  // Tracking state.
  logic                         known_r, known_nxt;
  logic                         last_lvl_r, last_lvl_nxt;
  logic [sspst_pkg::DIR_W-1:0]  ldir_r, ldir_nxt;
  logic [CB-1:0]                count_r, count_nxt;
  logic [TB-1:0]                t_new_r, t_new_nxt;
  logic [TB-1:0]                t_mid_r, t_mid_nxt;
  logic [TB-1:0]                t_old_r, t_old_nxt;

  // Speed and height working registers.
  logic [TB-1:0]                    delta_r;
  logic [TB:0]                      rem_r;
  logic [sspst_pkg::DIVD_W-1:0]     quo_r;
  logic                             spd_zero_r, spd_sat_r;
  logic signed [sspst_pkg::PROD_W-1:0] prod_r;

  // Output register.
  logic [sspst_pkg::RES_W-1:0]  out_height_r, out_speed_r;
  logic [sspst_pkg::DIR_W-1:0]  out_dir_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_int_r <= sspst_pkg::MIN_INTERVAL_RST;
      step_r    <= sspst_pkg::STEP_DIST_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        sspst_pkg::CFG_MIN_INTERVAL: min_int_r <= cfg_wdata;
        sspst_pkg::CFG_STEP_DIST:    step_r    <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      now_r <= in_tdata[TB-1:0];
      lvl_r <= in_tdata[sspst_pkg::NOW_W];
      dir_r <= in_tdata[sspst_pkg::NOW_W+1 +: sspst_pkg::DIR_W];
    end
  end

  // State update for one sample.
  logic [TB-1:0]               since_last;
  logic [sspst_pkg::DIR_W-1:0] dir_sel;

  always_comb begin
    known_nxt    = known_r;
    last_lvl_nxt = last_lvl_r;
    ldir_nxt     = ldir_r;
    count_nxt    = count_r;
    t_new_nxt    = t_new_r;
    t_mid_nxt    = t_mid_r;
    t_old_nxt    = t_old_r;
    since_last   = now_r - t_new_r;
    dir_sel      = ((dir_r == sspst_pkg::DIR_UP) || (dir_r == sspst_pkg::DIR_DOWN)) ?
                   dir_r : ldir_r;
    if (!known_r) begin
      known_nxt    = 1'b1;
      last_lvl_nxt = lvl_r;
    end else if ((lvl_r != last_lvl_r) &&
                 (since_last >= TB'(min_int_r))) begin
      t_old_nxt    = t_mid_r;
      t_mid_nxt    = t_new_r;
      t_new_nxt    = now_r;
      last_lvl_nxt = lvl_r;
      ldir_nxt     = dir_sel;
      if (dir_sel == sspst_pkg::DIR_UP) begin
        count_nxt = count_r + CB'(1);
      end else if (dir_sel == sspst_pkg::DIR_DOWN) begin
        count_nxt = count_r - CB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      known_r    <= 1'b0;
      last_lvl_r <= 1'b0;
      ldir_r     <= sspst_pkg::DIR_STOP;
      count_r    <= '0;
      t_new_r    <= '0;
      t_mid_r    <= '0;
      t_old_r    <= '0;
    end else if (cmd.update) begin
      known_r    <= known_nxt;
      last_lvl_r <= last_lvl_nxt;
      ldir_r     <= ldir_nxt;
      count_r    <= count_nxt;
      t_new_r    <= t_new_nxt;
      t_mid_r    <= t_mid_nxt;
      t_old_r    <= t_old_nxt;
    end
  end

  // Divisor: larger of the current and the previous two-change interval.
  logic [TB-1:0] d_cur, d_prev, d_sel;
  logic [TB:0]   rem_sh;
  logic          rem_ge;

  assign d_cur  = now_r - t_mid_r;
  assign d_prev = t_new_r - t_old_r;
  assign d_sel  = ((t_old_r != '0) && (d_prev > d_cur)) ? d_prev : d_cur;
  assign rem_sh = {rem_r[TB-1:0], quo_r[sspst_pkg::DIVD_W-1]};
  assign rem_ge = rem_sh >= {1'b0, delta_r};

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      delta_r    <= d_sel;
      spd_zero_r <= (t_mid_r == '0);
      spd_sat_r  <= (d_sel == '0);
      rem_r      <= '0;
      quo_r      <= {step_r, {sspst_pkg::SPEED_SHIFT{1'b0}}};
      prod_r     <= sspst_pkg::PROD_W'($signed(count_r)) *
                    sspst_pkg::PROD_W'($signed({1'b0, step_r}));
    end else if (cmd.div_step) begin
      rem_r <= rem_ge ? (rem_sh - {1'b0, delta_r}) : rem_sh;
      quo_r <= {quo_r[sspst_pkg::DIVD_W-2:0], rem_ge};
    end
  end

  // Saturate the height to the signed 32-bit range.
  logic signed [sspst_pkg::EXT_W-1:0] prod_ext;
  logic                               prod_fits;
  logic [sspst_pkg::RES_W-1:0]        height_sat, speed_val;

  assign prod_ext  = sspst_pkg::EXT_W'(prod_r);
  assign prod_fits = (prod_ext[sspst_pkg::EXT_W-1:sspst_pkg::RES_W-1] == '0) ||
                     (prod_ext[sspst_pkg::EXT_W-1:sspst_pkg::RES_W-1] == '1);
  assign height_sat = prod_fits ? prod_ext[sspst_pkg::RES_W-1:0] :
                      (prod_ext[sspst_pkg::EXT_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF);
  assign speed_val = spd_zero_r ? '0 :
                     spd_sat_r  ? '1 : sspst_pkg::RES_W'(quo_r);

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_height_r <= height_sat;
      out_speed_r  <= speed_val;
      out_dir_r    <= ldir_r;
    end
  end

  assign out_tdata = {{(sspst_pkg::OUT_W - sspst_pkg::OUT_RAW_W){1'b0}},
                      out_dir_r, out_speed_r, out_height_r};

endmodule

/* rtl/sspst_ctrl.sv */
// Controller of the slot sensor tracker: sequences update, setup, division
// steps and output load, and owns both stream handshakes.
// Depends on sspst_pkg.
module sspst_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  output logic            out_tvalid,
  input  logic            out_tready,
  output sspst_pkg::cmd_t cmd
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_UPD  = 5'b00010,
    S_PREP = 5'b00100,
    S_DIV  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  localparam logic [sspst_pkg::CNT_W-1:0] CNT_LAST =
    sspst_pkg::CNT_W'(sspst_pkg::DIV_STEPS - 1);

  state_t                       state_r, state_nxt;
  logic [sspst_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic                         ov_r, ov_nxt;
  logic                         out_free;

  assign out_free   = !ov_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;

  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    cmd          = '0;
    cmd.load_in  = in_tvalid && in_tready;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) state_nxt = S_UPD;
      end
      S_UPD: begin
        cmd.update = 1'b1;
        state_nxt  = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        cnt_nxt   = '0;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + sspst_pkg::CNT_W'(1);
        if (cnt_r == CNT_LAST) state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ov_nxt = cmd.load_out ? 1'b1 : (out_tready ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
    end
  end

  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!ov_r || out_tready))
    else $error("output register overwritten while holding an item");

  a_accept_upd: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_UPD))
    else $error("accepted item not followed by update");

  a_div_start: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PREP) |=> ((state_r == S_DIV) && (cnt_r == '0)))
    else $error("division did not start at step zero");

  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == S_DIV) && (cnt_r == CNT_LAST)) |=> (state_r == S_DONE))
    else $error("division ran past its last step");

endmodule

/* rtl/slot_sensor_position_speed_tracker.sv */
// Top level of the slot sensor position and speed tracker.
// Joins the controller and the datapath; depends on sspst_pkg, sspst_ctrl
// and sspst_dpath.

// Each input item is one sample of a slotted optical sensor (timestamp in
// ms, sensor level, motor command). The block debounces level changes,
// keeps a signed step count in the latched motor direction and returns one
// result item per sample: height in Q24.8, speed in Q16.16 and the latched
// direction. An item goes from acceptance to result in these steps: accept,
// update the tracking state, set up the divider and multiply the height,
// 25 steps of the restoring divider (one quotient bit per cycle, the
// dividend being step_distance * 512) and load the output register.
// in_tready rises again the cycle after that load, so the block takes no new
// item before the last one's result is loaded; a result that waits in the
// output register does not hold back the next item until that item is ready
// to be loaded itself. Write cfg registers only while idle.
module slot_sensor_position_speed_tracker (
  input  logic                             clk,
  input  logic                             rst_n,
  // cfg: index 0 min_interval_ms, index 1 step_distance
  input  logic                             cfg_we,
  input  logic [sspst_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sspst_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // in_tdata from bit 0: now_ms[31:0], opto_level[32], motor_dir[34:33], zero pad
  input  logic [sspst_pkg::IN_W-1:0]       in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // out_tdata from bit 0: height[31:0], speed[63:32], last_dir[65:64], zero pad
  output logic [sspst_pkg::OUT_W-1:0]      out_tdata
);

  sspst_pkg::cmd_t cmd;

  // Sequence one item at a time and own the handshakes.
  sspst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  // Hold config, tracking state, divider and the output register.
  sspst_dpath u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_tdata  (in_tdata),
    .out_tdata (out_tdata)
  );

endmodule

/* sim/sspst_track_checker.sv */
// Result checker for the slot sensor position and speed tracker.
// Watches the register port and both streams, predicts each result item and
// compares it; depends on sspst_pkg only.
module sspst_track_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sspst_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [sspst_pkg::DATA_W-1:0]     cfg_wdata,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [sspst_pkg::IN_W-1:0]       in_tdata,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [sspst_pkg::OUT_W-1:0]      out_tdata,
  output int                               open_count,
  output int                               fail_count
);
  import sspst_pkg::*;

  localparam longint HEIGHT_MAX = 64'sd2147483647;
  localparam longint HEIGHT_MIN = -64'sd2147483648;

  typedef struct packed {
    logic [RES_W-1:0] height;
    logic [RES_W-1:0] speed;
    logic [DIR_W-1:0] dir;
  } reading_t;

  logic [DATA_W-1:0]     debounce_ms;
  logic [DATA_W-1:0]     step_len;
  logic                  level_seen;
  logic                  level_now;
  logic [DIR_W-1:0]      dir_latch;
  logic [COUNT_BITS-1:0] step_count;
  logic [TIME_BITS-1:0]  edge_newest;
  logic [TIME_BITS-1:0]  edge_middle;
  logic [TIME_BITS-1:0]  edge_oldest;

  reading_t expected_readings[$];
  reading_t want;
  reading_t got;
  int       misses;

  // Apply one sample to the tracked sensor state and work out its reading.
  task automatic track_sample(input logic [NOW_W-1:0] now_in, input logic lvl,
                              input logic [DIR_W-1:0] dir, output reading_t r);
    logic [TIME_BITS-1:0] now;
    logic [TIME_BITS-1:0] since;
    logic [TIME_BITS-1:0] span;
    logic [31:0]          dividend;
    longint               h;
    now = now_in[TIME_BITS-1:0];
    since = now - edge_newest;
    if (!level_seen) begin
      level_now = lvl;
      level_seen = 1'b1;
    end else if (lvl != level_now && since >= TIME_BITS'(debounce_ms)) begin
      edge_oldest = edge_middle;
      edge_middle = edge_newest;
      edge_newest = now;
      level_now = lvl;
      if (dir == DIR_UP || dir == DIR_DOWN) dir_latch = dir;
      if (dir_latch == DIR_UP) step_count = step_count + COUNT_BITS'(1);
      else if (dir_latch == DIR_DOWN) step_count = step_count - COUNT_BITS'(1);
    end

    h = longint'($signed(step_count)) * longint'(step_len);
    if (h > HEIGHT_MAX) h = HEIGHT_MAX;
    else if (h < HEIGHT_MIN) h = HEIGHT_MIN;
    r.height = h[RES_W-1:0];

    // Speed needs two stored changes; the older interval joins in once a
    // third change is on record.
    if (edge_middle == '0) begin
      r.speed = '0;
    end else begin
      since = now - edge_middle;
      if (edge_oldest != '0) begin
        span = edge_newest - edge_oldest;
        if (span > since) since = span;
      end
      if (since == '0) begin
        r.speed = '1;
      end else begin
        dividend = 32'(step_len) << SPEED_SHIFT;
        r.speed = dividend / 32'(since);
      end
    end
    r.dir = dir_latch;
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      debounce_ms = MIN_INTERVAL_RST;
      step_len = STEP_DIST_RST;
      level_seen = 1'b0;
      level_now = 1'b0;
      dir_latch = DIR_STOP;
      step_count = '0;
      edge_newest = '0;
      edge_middle = '0;
      edge_oldest = '0;
      misses = 0;
      expected_readings.delete();
      open_count <= 0;
      fail_count <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_MIN_INTERVAL) debounce_ms = cfg_wdata;
        else if (cfg_addr == CFG_STEP_DIST) step_len = cfg_wdata;
      end
      if (in_tvalid && in_tready) begin
        track_sample(in_tdata[NOW_W-1:0], in_tdata[NOW_W],
                     in_tdata[NOW_W+DIR_W:NOW_W+1], want);
        expected_readings.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got.height = out_tdata[RES_W-1:0];
        got.speed  = out_tdata[2*RES_W-1:RES_W];
        got.dir    = out_tdata[2*RES_W+DIR_W-1:2*RES_W];
        if (expected_readings.size() == 0) begin
          misses++;
          if (misses <= 10)
            $display("unexpected result item: height %0d speed %h dir %0d",
                     $signed(got.height), got.speed, got.dir);
        end else begin
          want = expected_readings.pop_front();
          if (got.height !== want.height || got.speed !== want.speed ||
              got.dir !== want.dir) begin
            misses++;
            if (misses <= 10)
              $display({"result mismatch: height exp %0d got %0d, ",
                        "speed exp %h got %h, dir exp %0d got %0d"},
                       $signed(want.height), $signed(got.height),
                       want.speed, got.speed, want.dir, got.dir);
          end
        end
      end
      open_count <= expected_readings.size();
      fail_count <= misses;
    end
  end

endmodule

/* sim/slot_sensor_position_speed_tracker_test.sv */
// Testbench top for the slot sensor position and speed tracker.
// Drives samples and register writes, idles both streams; depends on
// sspst_pkg, the block and sspst_track_checker.
module slot_sensor_position_speed_tracker_test;
  import sspst_pkg::*;

  localparam logic [DIR_W-1:0] DIR_UNKNOWN = 2'd3;
  localparam int IN_PAD      = IN_W - IN_RAW_W;
  localparam int DRAIN_TAIL  = 40;         // a little over one item's latency
  localparam int CYCLE_LIMIT = 200000;     // several times the slowest clean run
  localparam int CLIMB_RUN   = 60;         // rapid changes with no debounce
  localparam int RANDOM_RUN  = 220;        // items per random setting
  localparam int HOLD_CYCLES = 400;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [DATA_W-1:0]     cfg_wdata = '0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  // in_tdata from bit 0: now_ms[31:0], opto_level[32], motor_dir[34:33], zero pad
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  // out_tdata from bit 0: height[31:0], speed[63:32], last_dir[65:64], zero pad
  logic [OUT_W-1:0]      out_tdata;

  int   open_count;
  int   fail_count;
  int   cycle_count = 0;
  int   sink_wait = 0;
  int   sink_pause;
  int   random_sent = 0;
  logic sink_hold = 1'b0;
  logic quiet = 1'b0;      // set to run both sides without any idling

  always #5 clk = ~clk;

  slot_sensor_position_speed_tracker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  sspst_track_checker track_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .open_count (open_count),
    .fail_count (fail_count)
  );

  // Idle gap before the next item: often none, otherwise a random draw.
  function automatic int pick_gap();
    if (quiet) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  // Offer one sample after a random gap and hold it until the block takes it.
  // Keep in_tvalid high on the way out so back-to-back items need no toggle.
  task automatic offer_sample(input logic [NOW_W-1:0] t, input logic lvl,
                              input logic [DIR_W-1:0] dir);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{IN_PAD{1'b0}}, dir, lvl, t};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Drop the stream, wait for every result item, then let the block settle.
  task automatic finish_phase();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (open_count != 0);
    repeat (DRAIN_TAIL) @(posedge clk);
  endtask

  // Write both registers on back-to-back edges while the block is idle.
  task automatic load_settings(input logic [DATA_W-1:0] debounce,
                               input logic [DATA_W-1:0] step);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_MIN_INTERVAL;
    cfg_wdata <= debounce;
    @(posedge clk);
    cfg_addr  <= CFG_STEP_DIST;
    cfg_wdata <= step;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Result side: draw a stall after each taken item; a long hold overrides.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
      sink_wait  <= 0;
    end else if (sink_hold) begin
      out_tready <= 1'b0;
    end else if (out_tready) begin
      if (out_tvalid) begin
        sink_pause = pick_gap();
        sink_wait  <= sink_pause;
        out_tready <= (sink_pause == 0);
      end
    end else if (sink_wait > 1) begin
      sink_wait <= sink_wait - 1;
    end else begin
      sink_wait  <= 0;
      out_tready <= 1'b1;
    end
  end

  // Long hold on the result side early in the random part: the sender keeps
  // offering, so the block fills its output register and stalls its input.
  initial begin
    wait (random_sent >= 60);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    sink_hold <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    logic [NOW_W-1:0]  t;
    logic              lvl;
    logic [DIR_W-1:0]  dir;
    logic [NOW_W-1:0]  cur_t;
    logic              cur_lvl;
    logic [DATA_W-1:0] gap_min;
    int                roll;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: 50 ms debounce, one unit per step.
    // The first sample only records the level.
    offer_sample(32'd100, 1'b1, DIR_STOP);
    // Accepted change, latch rising.
    offer_sample(32'd100, 1'b0, DIR_UP);
    // One ms short of the debounce interval: ignored, level not stored.
    offer_sample(32'd149, 1'b1, DIR_UP);
    // Exactly on the interval: accepted, stopped motor keeps rising latched.
    offer_sample(32'd150, 1'b1, DIR_STOP);
    // Same level, unknown motor code.
    offer_sample(32'd180, 1'b1, DIR_UNKNOWN);
    // Third change: the older interval now enters the speed.
    offer_sample(32'd250, 1'b0, DIR_UNKNOWN);
    offer_sample(32'd260, 1'b0, DIR_DOWN);
    offer_sample(32'd400, 1'b1, DIR_DOWN);
    // Top of the time range, then wrap past zero.
    offer_sample(32'hFFFF_FFF0, 1'b0, DIR_DOWN);
    offer_sample(32'h0000_0040, 1'b1, DIR_STOP);
    // Change at time zero, which later reads as never.
    offer_sample(32'd0, 1'b0, DIR_STOP);
    offer_sample(32'd30, 1'b1, DIR_UP);
    offer_sample(32'd60, 1'b1, DIR_UP);
    finish_phase();

    // No debounce and the widest step: changes at one instant give a zero
    // divisor, and a run of rapid changes climbs the step count.
    load_settings(16'd0, 16'hFFFF);
    offer_sample(32'd60, 1'b0, DIR_UP);
    offer_sample(32'd60, 1'b1, DIR_UP);
    offer_sample(32'd61, 1'b1, DIR_UP);
    cur_t   = 32'd61;
    cur_lvl = 1'b1;
    quiet <= 1'b1;
    for (int i = 0; i < CLIMB_RUN; i++) begin
      t = cur_t + $urandom_range(0, 3);
      roll = $urandom_range(0, 2);
      if (i == 0 || roll == 1) dir = DIR_UP;
      else if (roll == 0) dir = DIR_STOP;
      else dir = DIR_UNKNOWN;
      offer_sample(t, ~cur_lvl, dir);
      cur_t   = t;
      cur_lvl = ~cur_lvl;
    end
    quiet <= 1'b0;
    finish_phase();

    // Longest debounce and the smallest step: hit both sides of the bound.
    load_settings(16'hFFFF, 16'd1);
    offer_sample(cur_t + 32'd65534, ~cur_lvl, DIR_DOWN);
    offer_sample(cur_t + 32'd65535, ~cur_lvl, DIR_DOWN);
    offer_sample(32'hFFFF_FFFF, cur_lvl, DIR_UP);
    cur_t = 32'hFFFF_FFFF;
    finish_phase();

    // Random part: three settings, mostly plausible sensor traffic around the
    // debounce interval, with some wild time jumps and odd motor codes.
    for (int s = 0; s < 3; s++) begin
      if (s == 0) begin
        gap_min = 16'($urandom_range(0, 300));
        load_settings(gap_min, 16'($urandom_range(1, 65535)));
      end else if (s == 1) begin
        gap_min = 16'($urandom_range(0, 20));
        load_settings(gap_min, 16'($urandom_range(1, 1024)));
      end else begin
        gap_min = 16'($urandom_range(1000, 65535));
        load_settings(gap_min, 16'hFFFF);
      end
      for (int i = 0; i < RANDOM_RUN; i++) begin
        if (i % 50 == 0) quiet <= ($urandom_range(0, 3) == 0);
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          t   = $urandom;
          lvl = 1'($urandom_range(0, 1));
          dir = 2'($urandom_range(0, 3));
        end else begin
          if (roll < 70) t = cur_t + gap_min + $urandom_range(0, gap_min / 2 + 8);
          else t = cur_t + $urandom_range(0, gap_min);
          lvl = ($urandom_range(0, 9) < 7) ? ~cur_lvl : cur_lvl;
          roll = $urandom_range(0, 9);
          if (roll < 3) dir = DIR_UP;
          else if (roll < 6) dir = DIR_DOWN;
          else if (roll < 9) dir = DIR_STOP;
          else dir = DIR_UNKNOWN;
        end
        offer_sample(t, lvl, dir);
        cur_t   = t;
        cur_lvl = lvl;
        random_sent++;
      end
      quiet <= 1'b0;
      finish_phase();
    end

    if (fail_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
